// ===== hw/rtl/encoder_speed_and_drive_command_macros.svh =====
// Assertion macros for the encoder speed and drive command block.
// Used by the top level only; expands to nothing under SYNTHESIS.
`ifndef ENCODER_SPEED_AND_DRIVE_COMMAND_MACROS_SVH
`define ENCODER_SPEED_AND_DRIVE_COMMAND_MACROS_SVH
`ifndef SYNTHESIS
`define ESDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ESDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ESDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ESDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/esdc_pkg.sv =====
// Shared types, codes and constants of the encoder speed and drive command block.
// No dependencies; used by every module of the block.
package esdc_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int WRAP_BITS    = 16;

    localparam logic [63:0] COUNTER_MASK = (64'd1 << COUNTER_BITS) - 64'd1;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SPEED_GAIN    = 1'b0;
    localparam t_cfg_idx CFG_POSITION_GAIN = 1'b1;

    localparam logic [32:0] SPEED_GAIN_RST    = 33'd6757296;
    localparam logic [32:0] POSITION_GAIN_RST = 33'd67572;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_UP   = 2'd1,
        TREND_DOWN = 2'd2
    } t_trend;

    typedef enum logic [1:0] {
        BRK_NONE    = 2'd0,
        BRK_STOP    = 2'd1,
        BRK_RELEASE = 2'd2,
        BRK_DECEL   = 2'd3
    } t_brake;

    localparam logic [1:0] STEER_FWD = 2'd1;
    localparam logic [1:0] STEER_OFF = 2'd2;

    localparam logic [6:0]  THROTTLE_MAX   = 7'd100;
    localparam logic [15:0] DRIVE_MUL      = 16'd419;
    localparam int          CODE_PART_BITS = 14;
    localparam int          QUOT_BITS      = 30;
    localparam logic [29:0] DIV5_RECIP     = 30'd52429;
    localparam int          DIV5_SHIFT     = 18;
    localparam logic [11:0] DRIVE_BASE     = 12'd2000;
    localparam logic [5:0]  BRAKE_FULL     = 6'd50;

    localparam logic [63:0] ROUND_HALF = 64'd128;
    localparam int          Q_SHIFT    = 8;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef struct packed {
        logic                      auto_mode;
        logic                      sp_zero;
        t_trend                    trend;
        logic [1:0]                steer;
    } t_ctrl;

    typedef struct packed {
        logic [31:0]               delta;
        logic [31:0]               ext;
        logic [CODE_PART_BITS-1:0] code_part;
        t_ctrl                     ctrl;
    } t_item;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        abs32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] sat_q16(input logic [63:0] prod, input logic neg);
        logic [63:0] r;
        r = (prod + ROUND_HALF) >> Q_SHIFT;
        if (!neg) begin
            sat_q16 = (r > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        end else begin
            sat_q16 = (r >= 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - r[31:0]);
        end
    endfunction

endpackage

// ===== hw/rtl/esdc_front.sv =====
// Front end: accepts sample ticks, extends the encoder count and classifies the throttle.
// Depends on esdc_pkg; feeds esdc_queue.
module esdc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_counter_value,
    input  logic                  i_counting_down,
    input  logic                  i_overflow_seen,
    input  logic                  i_auto_mode,
    input  logic [7:0]            i_throttle_setpoint,
    input  logic [1:0]            i_steer_cmd,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output esdc_pkg::t_item       o_item
);

    logic [esdc_pkg::WRAP_BITS-1:0] r_wrap;
    logic [esdc_pkg::WRAP_BITS-1:0] n_wrap;
    logic [31:0]                    r_last_ext;
    logic [6:0]                     r_prev_sp;
    esdc_pkg::t_trend               r_trend;
    esdc_pkg::t_trend               n_trend;
    logic [63:0]                    w_ext64;
    logic [31:0]                    w_ext;
    logic [6:0]                     w_sp;
    logic [15:0]                    w_code_mul;
    logic                           w_accept;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;
    assign o_push     = w_accept;

    always_comb begin
        if (i_overflow_seen) begin
            n_wrap = i_counting_down ? (r_wrap - 1'b1) : (r_wrap + 1'b1);
        end else begin
            n_wrap = r_wrap;
        end
    end

    assign w_ext64 = (64'($signed(n_wrap)) << esdc_pkg::COUNTER_BITS)
                   | (64'(i_counter_value) & esdc_pkg::COUNTER_MASK);
    assign w_ext   = w_ext64[31:0];

    assign w_sp = (i_throttle_setpoint > 8'(esdc_pkg::THROTTLE_MAX)) ?
                  esdc_pkg::THROTTLE_MAX : i_throttle_setpoint[6:0];
    assign w_code_mul = 16'(w_sp) * esdc_pkg::DRIVE_MUL;

    always_comb begin
        n_trend = r_trend;
        if (i_auto_mode && (w_sp != 7'd0)) begin
            if (w_sp > r_prev_sp) begin
                n_trend = esdc_pkg::TREND_UP;
            end else if (w_sp < r_prev_sp) begin
                n_trend = esdc_pkg::TREND_DOWN;
            end
        end
    end

    always_comb begin
        o_item.delta          = w_ext - r_last_ext;
        o_item.ext            = w_ext;
        o_item.code_part      = w_code_mul[15:2];
        o_item.ctrl.auto_mode = i_auto_mode;
        o_item.ctrl.sp_zero   = (w_sp == 7'd0);
        o_item.ctrl.trend     = n_trend;
        o_item.ctrl.steer     = i_steer_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap     <= '1;
            r_last_ext <= '0;
            r_prev_sp  <= '0;
            r_trend    <= esdc_pkg::TREND_NONE;
        end else if (w_accept) begin
            r_wrap     <= n_wrap;
            r_last_ext <= w_ext;
            if (i_auto_mode) begin
                r_prev_sp <= w_sp;
                r_trend   <= n_trend;
            end
        end
    end

endmodule

// ===== hw/rtl/esdc_queue.sv =====
// Short item queue between the front and the back end.
// Depends on esdc_pkg for the item type and depth.
module esdc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  esdc_pkg::t_item  i_item,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop,
    output esdc_pkg::t_item  o_item
);

    esdc_pkg::t_item               r_mem [esdc_pkg::QUEUE_DEPTH];
    logic [esdc_pkg::QUEUE_AW-1:0] r_wr;
    logic [esdc_pkg::QUEUE_AW-1:0] r_rd;
    logic [esdc_pkg::QUEUE_AW:0]   r_count;
    logic                          w_pop;

    assign o_ready = (r_count != (esdc_pkg::QUEUE_AW + 1)'(esdc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/esdc_back.sv =====
// Back end: scales count change and position, forms the drive code and brake request.
// Depends on esdc_pkg; fed by esdc_queue, drives the result register.
module esdc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_pop,
    input  esdc_pkg::t_item      i_item,
    input  logic [31:0]          i_speed_gain,
    input  logic [31:0]          i_position_gain,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_speed_q16,
    output logic signed [31:0]   o_position_q16,
    output logic                 o_drive_valid,
    output logic [11:0]          o_drive_code,
    output logic [1:0]           o_brake_request,
    output logic [5:0]           o_brake_strength,
    output logic                 o_relay_write,
    output logic                 o_relay_level
);

    logic en1, en2, en3, en4;

    logic                                r1_valid;
    logic [31:0]                         r1_mag_s, r1_mag_p;
    logic                                r1_neg_s, r1_neg_p;
    logic [esdc_pkg::CODE_PART_BITS-1:0] r1_code_part;
    esdc_pkg::t_ctrl                     r1_ctrl;

    logic                                r2_valid;
    logic [63:0]                         r2_prod_s, r2_prod_p;
    logic                                r2_neg_s, r2_neg_p;
    logic [11:0]                         r2_quot;
    esdc_pkg::t_ctrl                     r2_ctrl;
    logic [esdc_pkg::QUOT_BITS-1:0]      w_quot_full;

    logic                                r3_valid;
    logic [31:0]                         r3_speed, r3_pos;
    logic [11:0]                         r3_code;
    esdc_pkg::t_ctrl                     r3_ctrl;

    logic                                r_out_valid;
    logic [31:0]                         r_speed, r_pos;
    logic                                r_drive_valid, n_drive_valid;
    logic [11:0]                         r_code, n_code;
    esdc_pkg::t_brake                    r_brake, n_brake;
    logic [5:0]                          r_strength, n_strength;
    logic                                r_rw, n_rw, r_rl, n_rl;
    logic [31:0]                         r_prev_speed;
    esdc_pkg::t_brake                    r_last_brake;

    assign en4   = !r_out_valid || i_out_ready;
    assign en3   = !r3_valid || en4;
    assign en2   = !r2_valid || en3;
    assign en1   = !r1_valid || en2;
    assign o_pop = i_valid && en1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mag_s     <= esdc_pkg::abs32(i_item.delta);
            r1_neg_s     <= i_item.delta[31];
            r1_mag_p     <= esdc_pkg::abs32(i_item.ext);
            r1_neg_p     <= i_item.ext[31];
            r1_code_part <= i_item.code_part;
            r1_ctrl      <= i_item.ctrl;
        end
    end

    assign w_quot_full = esdc_pkg::QUOT_BITS'(r1_code_part) * esdc_pkg::DIV5_RECIP;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_prod_s <= {32'd0, r1_mag_s} * {32'd0, i_speed_gain};
            r2_prod_p <= {32'd0, r1_mag_p} * {32'd0, i_position_gain};
            r2_neg_s  <= r1_neg_s;
            r2_neg_p  <= r1_neg_p;
            r2_quot   <= w_quot_full[esdc_pkg::DIV5_SHIFT +: 12];
            r2_ctrl   <= r1_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_speed <= esdc_pkg::sat_q16(r2_prod_s, r2_neg_s);
            r3_pos   <= esdc_pkg::sat_q16(r2_prod_p, r2_neg_p);
            r3_code  <= r2_ctrl.sp_zero ? 12'd0 : (esdc_pkg::DRIVE_BASE + r2_quot);
            r3_ctrl  <= r2_ctrl;
        end
    end

    always_comb begin
        n_drive_valid = 1'b0;
        n_code        = '0;
        n_brake       = esdc_pkg::BRK_NONE;
        n_strength    = '0;
        n_rw          = 1'b0;
        n_rl          = 1'b0;
        if (r3_ctrl.auto_mode) begin
            n_drive_valid = 1'b1;
            n_code        = r3_code;
            case (r3_ctrl.steer)
                esdc_pkg::STEER_FWD: begin
                    n_rw = 1'b1;
                    n_rl = 1'b1;
                end
                esdc_pkg::STEER_OFF: begin
                    n_rw = 1'b1;
                    n_rl = 1'b0;
                end
                default: begin
                    n_rw = 1'b0;
                    n_rl = 1'b0;
                end
            endcase
            if (r3_ctrl.sp_zero) begin
                n_strength = esdc_pkg::BRAKE_FULL;
                n_brake    = (r3_speed == 32'd0) ? esdc_pkg::BRK_STOP : esdc_pkg::BRK_RELEASE;
            end else begin
                case (r3_ctrl.trend)
                    esdc_pkg::TREND_DOWN: begin
                        n_brake = ($signed(r3_speed) < $signed(r_prev_speed)) ?
                                  esdc_pkg::BRK_DECEL : esdc_pkg::BRK_RELEASE;
                    end
                    esdc_pkg::TREND_UP: begin
                        n_brake = esdc_pkg::BRK_RELEASE;
                    end
                    default: begin
                        n_brake = r_last_brake;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_speed       <= r3_speed;
            r_pos         <= r3_pos;
            r_drive_valid <= n_drive_valid;
            r_code        <= n_code;
            r_brake       <= n_brake;
            r_strength    <= n_strength;
            r_rw          <= n_rw;
            r_rl          <= n_rl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_valid     <= 1'b0;
            r3_valid     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_speed <= '0;
            r_last_brake <= esdc_pkg::BRK_NONE;
        end else begin
            if (en1) begin
                r1_valid <= i_valid;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r_out_valid <= r3_valid;
                if (r3_valid && r3_ctrl.auto_mode) begin
                    r_prev_speed <= r3_speed;
                    r_last_brake <= n_brake;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_q16      = $signed(r_speed);
    assign o_position_q16   = $signed(r_pos);
    assign o_drive_valid    = r_drive_valid;
    assign o_drive_code     = r_code;
    assign o_brake_request  = r_brake;
    assign o_brake_strength = r_strength;
    assign o_relay_write    = r_rw;
    assign o_relay_level    = r_rl;

endmodule

// ===== hw/rtl/encoder_speed_and_drive_command.sv =====
// Top level of the encoder speed and drive command block: gain registers and wiring.
// Depends on esdc_pkg, esdc_front, esdc_queue, esdc_back and the macros header.
`include "encoder_speed_and_drive_command_macros.svh"

// One sample tick is accepted per clock cycle while the queue has room, and its result
// reaches the output register through the queue entry and the four back-end stages; the
// front end updates the wrap count and the last extended count on each accepted tick.
// The back end runs abs, the two 32x32 gain multiplies, rounding with saturation, and
// the brake decision as four registered stages, and a two-entry queue lets either side
// stall without stopping the other until it fills or empties. Gains are written through
// the configuration port, which is always ready; write them only while no tick is in flight.
module encoder_speed_and_drive_command (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [15:0]          i_counter_value,
    input  logic                 i_counting_down,
    input  logic                 i_overflow_seen,
    input  logic                 i_auto_mode,
    input  logic [7:0]           i_throttle_setpoint,
    input  logic [1:0]           i_steer_cmd,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [31:0]   o_speed_q16,
    output logic signed [31:0]   o_position_q16,
    output logic                 o_drive_valid,
    output logic [11:0]          o_drive_code,
    output logic [1:0]           o_brake_request,
    output logic [5:0]           o_brake_strength,
    output logic                 o_relay_write,
    output logic                 o_relay_level,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  esdc_pkg::t_cfg_idx   i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic [31:0]     r_speed_gain;
    logic [31:0]     r_position_gain;
    logic            w_push;
    logic            w_q_ready;
    logic            w_q_valid;
    logic            w_pop;
    esdc_pkg::t_item w_push_item;
    esdc_pkg::t_item w_head_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_gain    <= esdc_pkg::SPEED_GAIN_RST[31:0];
            r_position_gain <= esdc_pkg::POSITION_GAIN_RST[31:0];
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                esdc_pkg::CFG_SPEED_GAIN: begin
                    r_speed_gain <= i_cfg_data;
                end
                esdc_pkg::CFG_POSITION_GAIN: begin
                    r_position_gain <= i_cfg_data;
                end
                default: begin
                    r_speed_gain <= r_speed_gain;
                end
            endcase
        end
    end

    esdc_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_counter_value     (i_counter_value),
        .i_counting_down     (i_counting_down),
        .i_overflow_seen     (i_overflow_seen),
        .i_auto_mode         (i_auto_mode),
        .i_throttle_setpoint (i_throttle_setpoint),
        .i_steer_cmd         (i_steer_cmd),
        .i_q_ready           (w_q_ready),
        .o_push              (w_push),
        .o_item              (w_push_item)
    );

    esdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_head_item)
    );

    esdc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_q_valid),
        .o_pop            (w_pop),
        .i_item           (w_head_item),
        .i_speed_gain     (r_speed_gain),
        .i_position_gain  (r_position_gain),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_speed_q16      (o_speed_q16),
        .o_position_q16   (o_position_q16),
        .o_drive_valid    (o_drive_valid),
        .o_drive_code     (o_drive_code),
        .o_brake_request  (o_brake_request),
        .o_brake_strength (o_brake_strength),
        .o_relay_write    (o_relay_write),
        .o_relay_level    (o_relay_level)
    );

    `ESDC_ASSERT_NEXT(a_speed_gain_write, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready && (i_cfg_index == esdc_pkg::CFG_SPEED_GAIN), r_speed_gain == $past(i_cfg_data))
    `ESDC_ASSERT_SAME(a_full_brake_zero_code, i_clk, i_rst_n, o_out_valid && (o_brake_strength != 6'd0), o_drive_valid && (o_drive_code == 12'd0))
    `ESDC_ASSERT_SAME(a_relay_level_driven, i_clk, i_rst_n, o_out_valid && o_relay_level, o_relay_write && o_drive_valid)
    `ESDC_ASSERT_SAME(a_manual_quiet, i_clk, i_rst_n, o_out_valid && !o_drive_valid, (o_drive_code == 12'd0) && (o_brake_request == esdc_pkg::BRK_NONE) && !o_relay_write)

endmodule

// ===== tb/encoder_speed_and_drive_command_tb.sv =====
// Self-checking bench for encoder_speed_and_drive_command: directed and random sample
// ticks under varied gains and handshake pressure, checked against an in-bench predictor.
// Depends on esdc_pkg and the encoder_speed_and_drive_command top level.
module encoder_speed_and_drive_command_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import esdc_pkg::*;

    localparam int DRIVE_SPAN     = 2095;
    localparam int PERCENT        = 100;
    localparam int MAX_SHOWN      = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_TICKS   = 160;

    typedef struct {
        logic [15:0] count;
        logic        down;
        logic        ovf;
        logic        auto_on;
        logic [7:0]  throttle;
        logic [1:0]  steer;
    } tick_t;

    typedef struct {
        logic signed [31:0] speed;
        logic signed [31:0] position;
        logic               drive_valid;
        logic [11:0]        code;
        logic [1:0]         brake;
        logic [5:0]         strength;
        logic               relay_wr;
        logic               relay_lvl;
    } drive_result_t;

    class drive_ledger;
        logic [31:0]          speed_gain;
        logic [31:0]          position_gain;
        logic [WRAP_BITS-1:0] wraps;
        logic [31:0]          last_ext;
        logic [6:0]           last_setpoint;
        logic signed [31:0]   last_speed;
        t_trend               trend;
        t_brake               last_brake;
        drive_result_t        pending_results[$];
        int                   mismatches;
        int                   results_seen;

        function new();
            speed_gain    = SPEED_GAIN_RST[31:0];
            position_gain = POSITION_GAIN_RST[31:0];
            wraps         = '1;
            last_ext      = '0;
            last_setpoint = '0;
            last_speed    = '0;
            trend         = TREND_NONE;
            last_brake    = BRK_NONE;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void set_gain(t_cfg_idx idx, logic [31:0] value);
            if (idx == CFG_SPEED_GAIN) begin
                speed_gain = value;
            end else begin
                position_gain = value;
            end
        endfunction

        function logic signed [31:0] q16_scale(logic [31:0] v, logic [31:0] gain);
            logic [63:0] mag;
            logic [63:0] r;
            mag = v[31] ? {32'd0, 32'd0 - v} : {32'd0, v};
            r = (mag * {32'd0, gain} + 64'd128) >> 8;
            if (!v[31]) begin
                return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
            end
            return (r >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - r[31:0];
        endfunction

        function void take_tick(tick_t t);
            drive_result_t e;
            logic [31:0]   ext;
            logic [6:0]    sp;
            t_brake        brk;
            e = '{default: '0};
            if (t.ovf) begin
                wraps = t.down ? wraps - 1'b1 : wraps + 1'b1;
            end
            ext = {wraps, t.count};
            e.speed = q16_scale(ext - last_ext, speed_gain);
            e.position = q16_scale(ext, position_gain);
            last_ext = ext;
            if (t.auto_on) begin
                sp = (t.throttle > THROTTLE_MAX) ? THROTTLE_MAX : t.throttle[6:0];
                e.drive_valid = 1'b1;
                if (t.steer == STEER_FWD) begin
                    e.relay_wr  = 1'b1;
                    e.relay_lvl = 1'b1;
                end else if (t.steer == STEER_OFF) begin
                    e.relay_wr = 1'b1;
                end
                if (sp == '0) begin
                    e.strength = BRAKE_FULL;
                    brk = (e.speed == 0) ? BRK_STOP : BRK_RELEASE;
                end else begin
                    e.code = DRIVE_BASE + 12'((int'(sp) * DRIVE_SPAN) / PERCENT);
                    if (sp > last_setpoint) begin
                        trend = TREND_UP;
                    end else if (sp < last_setpoint) begin
                        trend = TREND_DOWN;
                    end
                    if (trend == TREND_DOWN) begin
                        brk = (e.speed < last_speed) ? BRK_DECEL : BRK_RELEASE;
                    end else if (trend == TREND_UP) begin
                        brk = BRK_RELEASE;
                    end else begin
                        brk = last_brake;
                    end
                end
                e.brake       = brk;
                last_brake    = brk;
                last_setpoint = sp;
                last_speed    = e.speed;
            end
            pending_results.push_back(e);
        endfunction

        function void match_result(drive_result_t got);
            drive_result_t e;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("result %0d arrived with nothing pending: speed %h pos %h",
                             results_seen, got.speed, got.position);
                end
                return;
            end
            e = pending_results.pop_front();
            if (got.speed !== e.speed || got.position !== e.position ||
                got.drive_valid !== e.drive_valid || got.code !== e.code ||
                got.brake !== e.brake || got.strength !== e.strength ||
                got.relay_wr !== e.relay_wr || got.relay_lvl !== e.relay_lvl) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("result %0d exp/act: speed %h/%h pos %h/%h valid %b/%b",
                             results_seen, e.speed, got.speed, e.position, got.position,
                             e.drive_valid, got.drive_valid);
                    $display("  code %0d/%0d brake %0d/%0d strength %0d/%0d relay %b%b/%b%b",
                             e.code, got.code, e.brake, got.brake, e.strength,
                             got.strength, e.relay_wr, e.relay_lvl, got.relay_wr,
                             got.relay_lvl);
                end
            end
        endfunction

        function int failures();
            return mismatches + pending_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [15:0]        i_counter_value;
    logic               i_counting_down;
    logic               i_overflow_seen;
    logic               i_auto_mode;
    logic [7:0]         i_throttle_setpoint;
    logic [1:0]         i_steer_cmd;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_speed_q16;
    logic signed [31:0] o_position_q16;
    logic               o_drive_valid;
    logic [11:0]        o_drive_code;
    logic [1:0]         o_brake_request;
    logic [5:0]         o_brake_strength;
    logic               o_relay_write;
    logic               o_relay_level;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [31:0]        i_cfg_data;

    drive_ledger   ledger = new();
    tick_t         seen_tick;
    drive_result_t seen_result;
    int            quiet_cycles = 0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    logic [15:0]   enc_count = '0;
    logic [7:0]    last_throttle = '0;

    encoder_speed_and_drive_command dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_counter_value     (i_counter_value),
        .i_counting_down     (i_counting_down),
        .i_overflow_seen     (i_overflow_seen),
        .i_auto_mode         (i_auto_mode),
        .i_throttle_setpoint (i_throttle_setpoint),
        .i_steer_cmd         (i_steer_cmd),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_speed_q16         (o_speed_q16),
        .o_position_q16      (o_position_q16),
        .o_drive_valid       (o_drive_valid),
        .o_drive_code        (o_drive_code),
        .o_brake_request     (o_brake_request),
        .o_brake_strength    (o_brake_strength),
        .o_relay_write       (o_relay_write),
        .o_relay_level       (o_relay_level),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                ledger.set_gain(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                seen_tick = '{i_counter_value, i_counting_down, i_overflow_seen,
                              i_auto_mode, i_throttle_setpoint, i_steer_cmd};
                ledger.take_tick(seen_tick);
            end
            if (o_out_valid && i_out_ready) begin
                seen_result = '{o_speed_q16, o_position_q16, o_drive_valid, o_drive_code,
                                o_brake_request, o_brake_strength, o_relay_write,
                                o_relay_level};
                ledger.match_result(seen_result);
            end
        end
        quiet_cycles <= ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                         (i_cfg_valid && o_cfg_ready)) ? 0 : quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic tick_t mk(logic [15:0] count, logic down, logic ovf, logic auto_on,
                                 logic [7:0] throttle, logic [1:0] steer);
        tick_t t;
        t = '{count, down, ovf, auto_on, throttle, steer};
        return t;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    base;
        int    step;
        int    nxt;
        if ($urandom_range(99) < 75) begin
            base = int'(enc_count);
            if ($urandom_range(9) == 0) begin
                base = $urandom_range(1) ? 65520 : 16;
            end
            step = int'($urandom_range(600)) - 300;
            nxt = base + step;
            t.down = (step < 0);
            t.ovf = (nxt < 0) || (nxt > 65535);
            t.count = nxt[15:0];
        end else begin
            t.count = 16'($urandom);
            t.down = 1'($urandom_range(1));
            t.ovf = 1'($urandom_range(1));
        end
        t.auto_on = ($urandom_range(9) != 0);
        case ($urandom_range(9))
            0, 1: t.throttle = '0;
            2: t.throttle = 8'($urandom_range(255, 101));
            3, 4: t.throttle = last_throttle;
            default: t.throttle = 8'($urandom_range(100, 1));
        endcase
        t.steer = 2'($urandom_range(3));
        enc_count = t.count;
        last_throttle = t.throttle;
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_counter_value     <= t.count;
        i_counting_down     <= t.down;
        i_overflow_seen     <= t.ovf;
        i_auto_mode         <= t.auto_on;
        i_throttle_setpoint <= t.throttle;
        i_steer_cmd         <= t.steer;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_tick(random_tick());
    endtask

    // drop valid and hold until every pending result has been taken
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gains(input logic [31:0] speed_g, input logic [31:0] position_g);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SPEED_GAIN;
        i_cfg_data  <= speed_g;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_POSITION_GAIN;
        i_cfg_data  <= position_g;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_counter_value     <= '0;
        i_counting_down     <= 1'b0;
        i_overflow_seen     <= 1'b0;
        i_auto_mode         <= 1'b0;
        i_throttle_setpoint <= '0;
        i_steer_cmd         <= '0;
        i_out_ready         <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= CFG_SPEED_GAIN;
        i_cfg_data          <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(mk(16'd0, 1'b0, 1'b0, 1'b0, 8'd0, 2'd0));
        send_tick(mk(16'd0, 1'b0, 1'b0, 1'b1, 8'd0, 2'd0));
        send_tick(mk(16'd5, 1'b0, 1'b0, 1'b1, 8'd0, 2'd1));
        send_tick(mk(16'd5, 1'b0, 1'b0, 1'b1, 8'd100, 2'd2));
        send_tick(mk(16'd10, 1'b0, 1'b0, 1'b1, 8'd255, 2'd3));
        send_tick(mk(16'd12, 1'b0, 1'b0, 1'b1, 8'd50, 2'd0));
        send_tick(mk(16'd40, 1'b0, 1'b0, 1'b1, 8'd50, 2'd1));
        send_tick(mk(16'd41, 1'b0, 1'b0, 1'b1, 8'd1, 2'd2));
        send_tick(mk(16'd41, 1'b0, 1'b0, 1'b0, 8'd101, 2'd1));
        send_tick(mk(16'd41, 1'b0, 1'b0, 1'b1, 8'd101, 2'd1));
        send_tick(mk(16'hFFFF, 1'b1, 1'b1, 1'b1, 8'd100, 2'd2));
        send_tick(mk(16'd0, 1'b0, 1'b1, 1'b1, 8'd100, 2'd0));
        send_tick(mk(16'hFFFF, 1'b0, 1'b0, 1'b1, 8'd99, 2'd1));
        send_tick(mk(16'd0, 1'b0, 1'b0, 1'b0, 8'd0, 2'd3));
        send_tick(mk(16'hAAAA, 1'b1, 1'b0, 1'b1, 8'h55, 2'd2));
        send_tick(mk(16'h5555, 1'b0, 1'b1, 1'b1, 8'hAA, 2'd1));
        send_tick(mk(16'd100, 1'b0, 1'b0, 1'b1, 8'd0, 2'd0));
        send_tick(mk(16'd100, 1'b0, 1'b0, 1'b1, 8'd0, 2'd0));
        enc_count = 16'd100;
        run_random(RANDOM_TICKS);

        settle();
        write_gains(32'd0, 32'hFFFF_FFFF);
        idle_pct = 57;
        run_random(RANDOM_TICKS);

        settle();
        write_gains(32'hFFFF_FFFF, 32'd0);
        idle_pct = 0;
        stall_pct = 57;
        run_random(RANDOM_TICKS);

        settle();
        write_gains($urandom, $urandom);
        idle_pct = 28;
        stall_pct = 28;
        run_random(RANDOM_TICKS);

        settle();
        write_gains(SPEED_GAIN_RST[31:0], POSITION_GAIN_RST[31:0]);
        idle_pct = 0;
        stall_pct = 0;
        run_random(RANDOM_TICKS);

        settle();
        repeat (8) @(posedge i_clk);
        if (ledger.failures() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
